/* hw/rtl/dspm_pkg.sv */
`default_nettype none

package dspm_pkg;

   // Widths of the transaction fields.
   localparam int ELAPSED_W = 10;
   localparam int AXIS_W    = 16;
   localparam int LIMIT_W   = 16;
   localparam int TIMER_W   = 17;

   // Fixed point: 16384 stands for 1.0.
   localparam logic signed [AXIS_W-1:0] AXIS_POS_ONE = 16'sd16384;
   localparam logic signed [AXIS_W-1:0] AXIS_NEG_ONE = -16'sd16384;

   // Hold limit after reset, in milliseconds.
   localparam logic [LIMIT_W-1:0] HOLD_LIMIT_RESET = 16'd45000;

   // The hold timer saturates here.
   localparam logic [TIMER_W-1:0] TIMER_MAX = 17'h1FFFF;

   // Largest value the timer can reach: the largest hold limit plus the largest tick.
   localparam logic [TIMER_W-1:0] TIMER_BOUND = 17'd66558;

   // One input transaction.
   typedef struct packed {
      logic [ELAPSED_W-1:0]     elapsed_ms;
      logic                     captain_button;
      logic                     officer_button;
      logic signed [AXIS_W-1:0] captain_pitch;
      logic signed [AXIS_W-1:0] captain_roll;
      logic signed [AXIS_W-1:0] officer_pitch;
      logic signed [AXIS_W-1:0] officer_roll;
   } dspm_req_type;

   // One result transaction.
   typedef struct packed {
      logic signed [AXIS_W-1:0] mixed_pitch;
      logic signed [AXIS_W-1:0] mixed_roll;
      logic                     captain_active;
      logic                     officer_active;
   } dspm_rsp_type;

   // Priority state carried from tick to tick.
   typedef struct packed {
      logic               captain_enable;
      logic               officer_enable;
      logic [TIMER_W-1:0] hold_timer;
      logic               captain_button_prev;
      logic               officer_button_prev;
   } dspm_state_type;

endpackage

`default_nettype wire

/* hw/rtl/dspm_step.sv */
`default_nettype none

module dspm_step (
   input  wire dspm_pkg::dspm_state_type state_cur,
   input  wire dspm_pkg::dspm_req_type   req,
   input  wire logic [15:0]              hold_limit_ms,
   output dspm_pkg::dspm_state_type      state_next,
   output dspm_pkg::dspm_rsp_type        rsp
);
   import dspm_pkg::*;

   // Negated sum of the enabled sticks, clamped to plus or minus one.
   function automatic logic signed [AXIS_W-1:0] mix_axis(
      input logic                     cap_en,
      input logic                     off_en,
      input logic signed [AXIS_W-1:0] cap,
      input logic signed [AXIS_W-1:0] off
   );
      logic signed [AXIS_W+1:0] sum;
      logic signed [AXIS_W+1:0] pos_one;
      logic signed [AXIS_W+1:0] neg_one;
      pos_one = {{2{AXIS_POS_ONE[AXIS_W-1]}}, AXIS_POS_ONE};
      neg_one = {{2{AXIS_NEG_ONE[AXIS_W-1]}}, AXIS_NEG_ONE};
      sum = '0;
      if (cap_en) begin
         sum = sum - {{2{cap[AXIS_W-1]}}, cap};
      end
      if (off_en) begin
         sum = sum - {{2{off[AXIS_W-1]}}, off};
      end
      if (sum > pos_one) begin
         mix_axis = AXIS_POS_ONE;
      end else if (sum < neg_one) begin
         mix_axis = AXIS_NEG_ONE;
      end else begin
         mix_axis = sum[AXIS_W-1:0];
      end
   endfunction

   logic [TIMER_W:0]   timer_sum;
   logic [TIMER_W-1:0] timer_counted;
   logic               timer_running;
   logic               captain_rise;
   logic               captain_fall;
   logic               officer_rise;
   logic               officer_fall;
   logic               limit_not_reached;

   // The timer runs while one stick holds sole control and the limit is not yet passed.
   assign timer_running = (!state_cur.captain_enable || !state_cur.officer_enable)
                          && (state_cur.hold_timer <= {1'b0, hold_limit_ms});
   assign timer_sum     = {1'b0, state_cur.hold_timer} + {{(TIMER_W+1-ELAPSED_W){1'b0}},
                                                          req.elapsed_ms};

   always_comb begin
      if (!timer_running) begin
         timer_counted = state_cur.hold_timer;
      end else if (timer_sum[TIMER_W]) begin
         timer_counted = TIMER_MAX;
      end else begin
         timer_counted = timer_sum[TIMER_W-1:0];
      end
   end

   // Button edges against the previous tick.
   assign captain_rise = !state_cur.captain_button_prev && req.captain_button;
   assign captain_fall = state_cur.captain_button_prev && !req.captain_button;
   assign officer_rise = !state_cur.officer_button_prev && req.officer_button;
   assign officer_fall = state_cur.officer_button_prev && !req.officer_button;

   // Rising edges grab control (the first officer wins a tie), then releases are checked.
   always_comb begin
      state_next = state_cur;
      state_next.hold_timer = timer_counted;
      if (captain_rise) begin
         state_next.captain_enable = 1'b1;
         state_next.officer_enable = 1'b0;
         state_next.hold_timer     = '0;
      end
      if (officer_rise) begin
         state_next.captain_enable = 1'b0;
         state_next.officer_enable = 1'b1;
         state_next.hold_timer     = '0;
      end
      limit_not_reached = state_next.hold_timer < {1'b0, hold_limit_ms};
      if ((captain_fall && state_next.captain_enable && limit_not_reached)
          || (officer_fall && state_next.officer_enable && limit_not_reached)) begin
         state_next.captain_enable = 1'b1;
         state_next.officer_enable = 1'b1;
      end
      state_next.captain_button_prev = req.captain_button;
      state_next.officer_button_prev = req.officer_button;
   end

   // Mix the axes with the enables after this tick.
   always_comb begin
      rsp.mixed_pitch    = mix_axis(state_next.captain_enable, state_next.officer_enable,
                                    req.captain_pitch, req.officer_pitch);
      rsp.mixed_roll     = mix_axis(state_next.captain_enable, state_next.officer_enable,
                                    req.captain_roll, req.officer_roll);
      rsp.captain_active = state_next.captain_enable;
      rsp.officer_active = state_next.officer_enable;
   end

endmodule

`default_nettype wire

/* hw/rtl/dual_stick_priority_mixer.sv */
// Dual side-stick priority mixer.
//
// Each request transaction carries one control tick: the milliseconds since
// the previous tick, both priority buttons and the pitch and roll of both
// sticks. Each tick yields exactly one response transaction with the mixed
// pitch and roll (negated sum of the active sticks, clamped to +-16384) and
// the two stick-active flags.
// The request is captured in an input register; the priority update and the
// mix run combinationally behind it and land in the response register. One
// tick can be accepted in every cycle while the receiver does not stall.
// When the receiver stalls, the response register holds and the input
// register still takes one more request, after which req_ready drops.
// The hold limit is written through csr_write_enable and csr_write_data; the user must
// write it only while no transaction is in flight, the block itself does not enforce this.
// Reset clears both stages, sets both sticks active, clears the hold timer and
// the button history, and loads the hold limit with 45000 ms.
`default_nettype none

module dual_stick_priority_mixer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [9:0]  req_elapsed_ms,
   input  wire logic        req_captain_button,
   input  wire logic        req_officer_button,
   input  wire logic signed [15:0] req_captain_pitch,
   input  wire logic signed [15:0] req_captain_roll,
   input  wire logic signed [15:0] req_officer_pitch,
   input  wire logic signed [15:0] req_officer_roll,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [15:0] rsp_mixed_pitch,
   output logic signed [15:0] rsp_mixed_roll,
   output logic             rsp_captain_active,
   output logic             rsp_officer_active,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data
);
   import dspm_pkg::*;

   logic           in_valid_ff, in_valid_in;
   dspm_req_type   in_req_ff, in_req_in;
   logic           out_valid_ff, out_valid_in;
   dspm_rsp_type   out_rsp_ff, out_rsp_in;
   dspm_state_type state_ff, state_in;
   dspm_state_type state_step;
   logic [LIMIT_W-1:0] hold_limit_ff, hold_limit_in;
   logic           req_take;
   logic           advance;

   // Handshake control: the input stage moves on when the response register is free.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_req_in.elapsed_ms     = req_elapsed_ms;
      in_req_in.captain_button = req_captain_button;
      in_req_in.officer_button = req_officer_button;
      in_req_in.captain_pitch  = req_captain_pitch;
      in_req_in.captain_roll   = req_captain_roll;
      in_req_in.officer_pitch  = req_officer_pitch;
      in_req_in.officer_roll   = req_officer_roll;
   end

   assign in_valid_in   = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in  = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   assign hold_limit_in = csr_write_enable ? csr_write_data : hold_limit_ff;

   // Priority update and mixing for the transaction in the input register.
   dspm_step u_step (
      .state_cur     (state_ff),
      .req           (in_req_ff),
      .hold_limit_ms (hold_limit_ff),
      .state_next    (state_step),
      .rsp           (out_rsp_in)
   );

   assign state_in = advance ? state_step : state_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                   <= 1'b0;
         out_valid_ff                  <= 1'b0;
         hold_limit_ff                 <= HOLD_LIMIT_RESET;
         state_ff.captain_enable       <= 1'b1;
         state_ff.officer_enable       <= 1'b1;
         state_ff.hold_timer           <= '0;
         state_ff.captain_button_prev  <= 1'b0;
         state_ff.officer_button_prev  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         hold_limit_ff <= hold_limit_in;
         state_ff      <= state_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff <= in_req_in;
      end
      if (advance) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_mixed_pitch    = out_rsp_ff.mixed_pitch;
   assign rsp_mixed_roll     = out_rsp_ff.mixed_roll;
   assign rsp_captain_active = out_rsp_ff.captain_active;
   assign rsp_officer_active = out_rsp_ff.officer_active;

   // At least one stick always has control.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.captain_enable || state_ff.officer_enable)
      else $error("both sticks disabled");

   // The hold timer never runs past the largest limit plus one tick.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.hold_timer <= TIMER_BOUND)
      else $error("hold timer beyond bound");

   // A delivered result carries clamped axes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mixed_pitch <= AXIS_POS_ONE) && (rsp_mixed_pitch >= AXIS_NEG_ONE)
                    && (rsp_mixed_roll <= AXIS_POS_ONE) && (rsp_mixed_roll >= AXIS_NEG_ONE))
      else $error("mixed axis out of range");

   // The flags in a new result match the state it left behind.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_captain_active == state_ff.captain_enable)
                  && (rsp_officer_active == state_ff.officer_enable))
      else $error("active flags differ from state");

endmodule

`default_nettype wire

/* dv/dspm_checker.sv */
`default_nettype none

module dspm_checker
   import dspm_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire logic [ELAPSED_W-1:0]     req_elapsed_ms,
   input  wire logic                     req_captain_button,
   input  wire logic                     req_officer_button,
   input  wire logic signed [AXIS_W-1:0] req_captain_pitch,
   input  wire logic signed [AXIS_W-1:0] req_captain_roll,
   input  wire logic signed [AXIS_W-1:0] req_officer_pitch,
   input  wire logic signed [AXIS_W-1:0] req_officer_roll,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire logic signed [AXIS_W-1:0] rsp_mixed_pitch,
   input  wire logic signed [AXIS_W-1:0] rsp_mixed_roll,
   input  wire logic                     rsp_captain_active,
   input  wire logic                     rsp_officer_active,
   input  wire logic                     csr_write_enable,
   input  wire logic [LIMIT_W-1:0]       csr_write_data,
   output int                            fail_count,
   output int                            pending
);

   // Own copy of the priority state and the hold limit.
   logic               captain_en;
   logic               officer_en;
   logic [TIMER_W-1:0] hold_ms;
   logic               captain_held;
   logic               officer_held;
   logic [LIMIT_W-1:0] limit_ms;

   // Mixes awaiting their response transaction, oldest first.
   dspm_rsp_type expected_mix_q[$];
   int           errors;

   // Negated sum of the active sticks on one axis, clamped to plus or minus 1.0.
   function automatic logic signed [AXIS_W-1:0] mix_axis_value(
      input logic cap_on,
      input logic off_on,
      input logic signed [AXIS_W-1:0] cap,
      input logic signed [AXIS_W-1:0] off
   );
      int s;
      s = 0;
      if (cap_on) s -= int'(cap);
      if (off_on) s -= int'(off);
      if (s > int'(AXIS_POS_ONE)) s = int'(AXIS_POS_ONE);
      if (s < int'(AXIS_NEG_ONE)) s = int'(AXIS_NEG_ONE);
      return AXIS_W'(s);
   endfunction

   // Advances the priority state by one tick and returns the mix it produces.
   function automatic dspm_rsp_type advance_priority(input dspm_req_type t);
      dspm_rsp_type     r;
      logic [TIMER_W:0] sum;
      logic             c_rise, c_fall, o_rise, o_fall;
      // The timer runs on the enables from before this tick and saturates.
      if ((!captain_en || !officer_en) && hold_ms <= TIMER_W'(limit_ms)) begin
         sum = {1'b0, hold_ms} + t.elapsed_ms;
         hold_ms = (sum > TIMER_MAX) ? TIMER_MAX : sum[TIMER_W-1:0];
      end
      c_rise = !captain_held && t.captain_button;
      c_fall = captain_held && !t.captain_button;
      o_rise = !officer_held && t.officer_button;
      o_fall = officer_held && !t.officer_button;
      // A press takes sole control; the first officer wins a simultaneous press.
      if (c_rise) begin
         captain_en = 1'b1;
         officer_en = 1'b0;
         hold_ms = '0;
      end
      if (o_rise) begin
         captain_en = 1'b0;
         officer_en = 1'b1;
         hold_ms = '0;
      end
      // An early release hands control back to both sticks; captain checked first.
      if (c_fall && captain_en && hold_ms < TIMER_W'(limit_ms)) begin
         captain_en = 1'b1;
         officer_en = 1'b1;
      end else if (o_fall && officer_en && hold_ms < TIMER_W'(limit_ms)) begin
         captain_en = 1'b1;
         officer_en = 1'b1;
      end
      captain_held = t.captain_button;
      officer_held = t.officer_button;
      r.mixed_pitch = mix_axis_value(captain_en, officer_en, t.captain_pitch, t.officer_pitch);
      r.mixed_roll = mix_axis_value(captain_en, officer_en, t.captain_roll, t.officer_roll);
      r.captain_active = captain_en;
      r.officer_active = officer_en;
      return r;
   endfunction

   // Watch both channels and the register port at every rising edge.
   always @(posedge clock) begin
      dspm_req_type tick;
      dspm_rsp_type want;
      if (reset) begin
         captain_en = 1'b1;
         officer_en = 1'b1;
         hold_ms = '0;
         captain_held = 1'b0;
         officer_held = 1'b0;
         limit_ms = HOLD_LIMIT_RESET;
         expected_mix_q.delete();
         errors = 0;
      end else begin
         if (csr_write_enable) limit_ms = csr_write_data;
         // Compare a response transaction against the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            if (expected_mix_q.size() == 0) begin
               $display("%0t: response transaction with nothing expected", $time);
               errors++;
            end else begin
               want = expected_mix_q.pop_front();
               if (rsp_mixed_pitch !== want.mixed_pitch) begin
                  $display("%0t: mixed_pitch expected %0d, got %0d", $time,
                           want.mixed_pitch, rsp_mixed_pitch);
                  errors++;
               end
               if (rsp_mixed_roll !== want.mixed_roll) begin
                  $display("%0t: mixed_roll expected %0d, got %0d", $time,
                           want.mixed_roll, rsp_mixed_roll);
                  errors++;
               end
               if (rsp_captain_active !== want.captain_active) begin
                  $display("%0t: captain_active expected %0b, got %0b", $time,
                           want.captain_active, rsp_captain_active);
                  errors++;
               end
               if (rsp_officer_active !== want.officer_active) begin
                  $display("%0t: officer_active expected %0b, got %0b", $time,
                           want.officer_active, rsp_officer_active);
                  errors++;
               end
            end
         end
         // Predict the mix for each accepted request transaction.
         if (req_valid && req_ready) begin
            tick.elapsed_ms = req_elapsed_ms;
            tick.captain_button = req_captain_button;
            tick.officer_button = req_officer_button;
            tick.captain_pitch = req_captain_pitch;
            tick.captain_roll = req_captain_roll;
            tick.officer_pitch = req_officer_pitch;
            tick.officer_roll = req_officer_roll;
            expected_mix_q.push_back(advance_priority(tick));
         end
      end
      fail_count <= errors;
      pending <= expected_mix_q.size();
   end

endmodule

`default_nettype wire

/* dv/tb.sv */
`default_nettype none

module tb;
   import dspm_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int LONG_HOLD  = 48;
   localparam int PHASES     = 8;
   localparam int PHASE_LEN  = 145;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [ELAPSED_W-1:0]     req_elapsed_ms;
   logic                     req_captain_button;
   logic                     req_officer_button;
   logic signed [AXIS_W-1:0] req_captain_pitch;
   logic signed [AXIS_W-1:0] req_captain_roll;
   logic signed [AXIS_W-1:0] req_officer_pitch;
   logic signed [AXIS_W-1:0] req_officer_roll;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [AXIS_W-1:0] rsp_mixed_pitch;
   logic signed [AXIS_W-1:0] rsp_mixed_roll;
   logic                     rsp_captain_active;
   logic                     rsp_officer_active;
   logic                     csr_write_enable;
   logic [LIMIT_W-1:0]       csr_write_data;

   int fail_count;
   int pending;
   int sender_gap_pct;
   int stall_pct;
   bit quiet_run;
   bit hold_off_request;
   bit cap_btn;
   bit off_btn;

   dual_stick_priority_mixer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_elapsed_ms     (req_elapsed_ms),
      .req_captain_button (req_captain_button),
      .req_officer_button (req_officer_button),
      .req_captain_pitch  (req_captain_pitch),
      .req_captain_roll   (req_captain_roll),
      .req_officer_pitch  (req_officer_pitch),
      .req_officer_roll   (req_officer_roll),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_mixed_pitch    (rsp_mixed_pitch),
      .rsp_mixed_roll     (rsp_mixed_roll),
      .rsp_captain_active (rsp_captain_active),
      .rsp_officer_active (rsp_officer_active),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   dspm_checker mix_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_elapsed_ms     (req_elapsed_ms),
      .req_captain_button (req_captain_button),
      .req_officer_button (req_officer_button),
      .req_captain_pitch  (req_captain_pitch),
      .req_captain_roll   (req_captain_roll),
      .req_officer_pitch  (req_officer_pitch),
      .req_officer_roll   (req_officer_roll),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_mixed_pitch    (rsp_mixed_pitch),
      .rsp_mixed_roll     (rsp_mixed_roll),
      .rsp_captain_active (rsp_captain_active),
      .rsp_officer_active (rsp_officer_active),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   // Free-running clock with a period of 10.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Stick values: mostly in range, often at plus or minus 1.0, sometimes any 16 bits.
   function automatic logic signed [AXIS_W-1:0] pick_axis();
      int v;
      case ($urandom_range(0, 9))
         0: v = int'(AXIS_POS_ONE);
         1: v = int'(AXIS_NEG_ONE);
         2: v = int'($urandom_range(0, 65535));
         default: v = int'($urandom_range(0, 32768)) - 16384;
      endcase
      return AXIS_W'(v);
   endfunction

   function automatic logic [ELAPSED_W-1:0] pick_elapsed();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return ELAPSED_W'($urandom_range(0, 1023));
      endcase
   endfunction

   function automatic dspm_req_type make_tick(
      input int el,
      input int cb,
      input int ob,
      input logic signed [AXIS_W-1:0] cp,
      input logic signed [AXIS_W-1:0] cr,
      input logic signed [AXIS_W-1:0] op,
      input logic signed [AXIS_W-1:0] orl
   );
      dspm_req_type t;
      t.elapsed_ms = ELAPSED_W'(el);
      t.captain_button = cb[0];
      t.officer_button = ob[0];
      t.captain_pitch = cp;
      t.captain_roll = cr;
      t.officer_pitch = op;
      t.officer_roll = orl;
      return t;
   endfunction

   // Offer one tick, after an optional gap, and wait until it is taken.
   task automatic send_tick(input dspm_req_type t);
      if (!quiet_run && $urandom_range(0, 99) < sender_gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_elapsed_ms <= t.elapsed_ms;
      req_captain_button <= t.captain_button;
      req_officer_button <= t.officer_button;
      req_captain_pitch <= t.captain_pitch;
      req_captain_roll <= t.captain_roll;
      req_officer_pitch <= t.officer_pitch;
      req_officer_roll <= t.officer_roll;
      do @(posedge clock); while (!req_ready);
   endtask

   // Button presses, holds and releases with random content; now and then both at once.
   task automatic random_tick(input int toggle_pct);
      if (!cap_btn && !off_btn && $urandom_range(0, 99) < 4) begin
         cap_btn = 1'b1;
         off_btn = 1'b1;
      end else begin
         if ($urandom_range(0, 99) < toggle_pct) cap_btn = !cap_btn;
         if ($urandom_range(0, 99) < toggle_pct) off_btn = !off_btn;
      end
      send_tick(make_tick(int'(pick_elapsed()), int'(cap_btn), int'(off_btn),
                          pick_axis(), pick_axis(), pick_axis(), pick_axis()));
   endtask

   // Stop offering and wait until every predicted response has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // The hold limit is only written with nothing in flight.
   task automatic write_hold_limit(input logic [LIMIT_W-1:0] value);
      drain();
      repeat (2) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Result side: random stall bursts, plus one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (quiet_run || $urandom_range(0, 99) >= stall_pct) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge clock);
         end
      end
   end

   // Watchdog: too long without any transaction on either channel.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      int toggle_pct;
      int saved_gap;
      logic [LIMIT_W-1:0] limit;
      reset = 1'b1;
      req_valid = 1'b0;
      req_elapsed_ms = '0;
      req_captain_button = 1'b0;
      req_officer_button = 1'b0;
      req_captain_pitch = '0;
      req_captain_roll = '0;
      req_officer_pitch = '0;
      req_officer_roll = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      sender_gap_pct = 20;
      stall_pct = 20;
      quiet_run = 1'b0;
      hold_off_request = 1'b0;
      cap_btn = 1'b0;
      off_btn = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Both sticks active, full deflection and out-of-range sums that clamp.
      send_tick(make_tick(0, 0, 0, AXIS_POS_ONE, AXIS_NEG_ONE, AXIS_POS_ONE, AXIS_NEG_ONE));
      send_tick(make_tick(1023, 0, 0, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767));
      // Captain takes priority, holds, releases early: both sticks back.
      send_tick(make_tick(5, 1, 0, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      send_tick(make_tick(1023, 1, 0, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      send_tick(make_tick(100, 0, 0, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      // Officer presses, captain overrides, officer release is then ignored.
      send_tick(make_tick(300, 0, 1, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      send_tick(make_tick(300, 1, 1, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      send_tick(make_tick(300, 1, 0, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      send_tick(make_tick(300, 0, 0, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      // Both press together: officer wins; both release: officer release applies.
      send_tick(make_tick(7, 1, 1, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      send_tick(make_tick(7, 0, 0, pick_axis(), pick_axis(), pick_axis(), pick_axis()));

      // Zero hold limit: every release keeps sole control.
      write_hold_limit('0);
      send_tick(make_tick(0, 1, 0, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      send_tick(make_tick(0, 0, 0, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      send_tick(make_tick(1023, 0, 0, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      send_tick(make_tick(1023, 0, 1, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      send_tick(make_tick(0, 0, 0, pick_axis(), pick_axis(), pick_axis(), pick_axis()));

      // Release one millisecond short of the limit, then exactly at it.
      write_hold_limit(16'd2000);
      send_tick(make_tick(1023, 1, 0, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      send_tick(make_tick(1000, 1, 0, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      send_tick(make_tick(999, 1, 0, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      send_tick(make_tick(0, 0, 0, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      send_tick(make_tick(0, 1, 0, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      send_tick(make_tick(1000, 1, 0, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      send_tick(make_tick(1000, 1, 0, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      send_tick(make_tick(0, 0, 0, pick_axis(), pick_axis(), pick_axis(), pick_axis()));
      send_tick(make_tick(1023, 0, 0, pick_axis(), pick_axis(), pick_axis(), pick_axis()));

      // Random phases, each with its own hold limit and idling mix.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: limit = '1;
            1: limit = '0;
            2: limit = LIMIT_W'($urandom_range(500, 3000));
            3: limit = LIMIT_W'($urandom_range(0, 65535));
            4: limit = 16'd1;
            5: limit = LIMIT_W'($urandom_range(1000, 5000));
            6: limit = HOLD_LIMIT_RESET;
            default: limit = LIMIT_W'($urandom_range(0, 3000));
         endcase
         write_hold_limit(limit);
         toggle_pct = $urandom_range(4, 30);
         sender_gap_pct = 10 * $urandom_range(0, 4);
         stall_pct = 10 * $urandom_range(0, 4);
         if (p == PHASES - 1) quiet_run = 1'b1;
         for (int i = 0; i < PHASE_LEN; i++) begin
            // Long receiver hold-off while the sender keeps offering back to back.
            if (p == 2 && i == 40) begin
               saved_gap = sender_gap_pct;
               sender_gap_pct = 0;
               hold_off_request = 1'b1;
               repeat (16) random_tick(toggle_pct);
               sender_gap_pct = saved_gap;
            end
            random_tick(toggle_pct);
         end
      end

      drain();
      repeat (6) @(posedge clock);
      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire

/* dual_stick_priority_mixer.f */
hw/rtl/dspm_pkg.sv
hw/rtl/dspm_step.sv
hw/rtl/dual_stick_priority_mixer.sv
dv/dspm_checker.sv
dv/tb.sv
